// ===== sv/pbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbp_pkg
// Shared types and fixed field widths of the perceptron branch predictor.
// ----------------------------------------------------------------------------
package pbp_pkg;

  localparam int ADDR_W     = 32;
  localparam int THR_W      = 11;
  localparam int OUT_SUM_W  = 12;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam int GROUP_SIZE = 8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PART,
    ST_SUM,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic part_en;
    logic final_en;
  } sum_ctrl_t;

endpackage

// ===== sv/perceptron_branch_predictor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perceptron_branch_predictor_top
// Perceptron branch predictor: weight table in RAM, read-sum-train-write.
// ----------------------------------------------------------------------------
// Channel  | Dir | Fields (low bit up)
// s_axis   | in  | tuser: mode; tdata: branch_address, resolved_taken
// m_axis   | out | tdata: predict_taken, perceptron_sum, weights_updated
// cfg      | in  | data: train_threshold
//
// A request passes through four steps: accept and RAM read, group sums, row sum,
// then train decision with row write-back and result load.
// After reset a clear pass writes zero to all 2^INDEX_BITS rows, one per
// cycle (256 rows by default); no request is taken meanwhile.
// A waiting result stalls only the final step; config is always taken.
// ----------------------------------------------------------------------------
module perceptron_branch_predictor_top #(
  parameter int INDEX_BITS      = 8,
  parameter int HISTORY_LEN     = 20,
  parameter int WEIGHT_MAG_BITS = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [pbp_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,  // branch_address, resolved_taken
  input  logic                             s_axis_tuser_i,  // mode
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [pbp_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,  // predict_taken, sum, updated
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pbp_pkg::THR_W-1:0]        cfg_data_i
);
  import pbp_pkg::*;

  localparam int ROWS      = 1 << INDEX_BITS;
  localparam int WW        = WEIGHT_MAG_BITS + 1;
  localparam int N         = HISTORY_LEN + 1;
  localparam int ROW_W     = N * WW;
  localparam int SUM_A     = $clog2(N << WEIGHT_MAG_BITS) + 2;
  localparam int SUM_W     = (SUM_A > OUT_SUM_W) ? SUM_A : OUT_SUM_W;
  localparam int HX        = (HISTORY_LEN > INDEX_BITS) ? HISTORY_LEN : INDEX_BITS;
  localparam int THR_RESET = (193 * HISTORY_LEN + 1400) / 100;
  localparam logic signed [WW-1:0] W_MAX = WW'((1 << WEIGHT_MAG_BITS) - 1);
  localparam logic signed [WW-1:0] W_MIN = WW'(-(1 << WEIGHT_MAG_BITS));

  state_e state_q, state_d;

  logic [INDEX_BITS-1:0]  clr_cnt_q, clr_cnt_d;
  logic [HISTORY_LEN-1:0] hist_q, hist_d;
  logic [THR_W-1:0]       thr_q;
  logic [INDEX_BITS-1:0]  idx_q, idx_in;
  logic                   mode_q, taken_q;
  logic [ROW_W-1:0]       row_q, new_row, ram_rdata, ram_wdata;
  logic [HX-1:0]          hist_x;
  logic                   ram_we, ram_re, load, in_acc;
  logic [INDEX_BITS-1:0]  ram_waddr;
  sum_ctrl_t              sum_ctrl;
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]       mag;
  logic                   pred, do_train;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0]  out_data_q;

  assign hist_x  = HX'(hist_q);
  assign idx_in  = s_axis_tdata_i[INDEX_BITS-1:0] ^ hist_x[INDEX_BITS-1:0];
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o = 1'b1;

  pbp_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_in),
    .rdata_o (ram_rdata)
  );

  pbp_sum #(.HISTORY_LEN(HISTORY_LEN), .WEIGHT_MAG_BITS(WEIGHT_MAG_BITS)) u_sum (
    .clk_i  (clk_i),
    .ctrl_i (sum_ctrl),
    .row_i  (ram_rdata),
    .hist_i (hist_q),
    .sum_o  (sum)
  );

  // train decision
  assign pred     = ~sum[SUM_W-1];
  assign mag      = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign do_train = mode_q && ((pred != taken_q) || (mag <= SUM_W'(thr_q)));

  always_comb begin
    logic signed [WW-1:0] w;
    logic inc;
    for (int j = 0; j < N; j++) begin
      w = row_q[j*WW +: WW];
      if (j == HISTORY_LEN) begin
        inc = taken_q;
      end else begin
        inc = ~(hist_q[j % HISTORY_LEN] ^ taken_q);
      end
      if (inc) begin
        new_row[j*WW +: WW] = (w == W_MAX) ? w : w + WW'(1);
      end else begin
        new_row[j*WW +: WW] = (w == W_MIN) ? w : w - WW'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (&clr_cnt_q) state_d = ST_IDLE;
      ST_IDLE:  if (s_axis_tvalid_i) state_d = ST_PART;
      ST_PART:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_FIN;
      ST_FIN:   if (!out_valid_q || m_axis_tready_i) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready_o  = 1'b0;
    ram_re           = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = idx_q;
    ram_wdata        = new_row;
    sum_ctrl         = '0;
    load             = 1'b0;
    clr_cnt_d        = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + INDEX_BITS'(1);
      end
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        ram_re          = s_axis_tvalid_i;
      end
      ST_PART: sum_ctrl.part_en = 1'b1;
      ST_SUM:  sum_ctrl.final_en = 1'b1;
      ST_FIN: begin
        load   = !out_valid_q || m_axis_tready_i;
        ram_we = load && do_train;
      end
      default: ;
    endcase
  end

  assign hist_d      = (load && mode_q) ? HISTORY_LEN'({hist_q, taken_q}) : hist_q;
  assign out_valid_d = load ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      hist_q      <= '0;
      thr_q       <= THR_W'(THR_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      hist_q      <= hist_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q   <= idx_in;
      mode_q  <= s_axis_tuser_i;
      taken_q <= s_axis_tdata_i[ADDR_W];
    end
    if (sum_ctrl.part_en) begin
      row_q <= ram_rdata;
    end
    if (load) begin
      out_data_q <= OUT_DATA_W'({do_train, sum[OUT_SUM_W-1:0], pred});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== sv/pbp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pbp_sum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbp_sum
// Two-stage registered adder tree: group partial sums, then the row sum.
// ----------------------------------------------------------------------------
module pbp_sum #(
  parameter int HISTORY_LEN     = 20,
  parameter int WEIGHT_MAG_BITS = 6
) (
  input  logic                     clk_i,
  input  pbp_pkg::sum_ctrl_t       ctrl_i,
  input  logic [(HISTORY_LEN+1)*(WEIGHT_MAG_BITS+1)-1:0] row_i,
  input  logic [HISTORY_LEN-1:0]   hist_i,
  output logic signed [((($clog2((HISTORY_LEN+1) << WEIGHT_MAG_BITS) + 2) > 12) ?
                        ($clog2((HISTORY_LEN+1) << WEIGHT_MAG_BITS) + 2) : 12)-1:0] sum_o
);
  import pbp_pkg::*;

  localparam int WW    = WEIGHT_MAG_BITS + 1;
  localparam int N     = HISTORY_LEN + 1;
  localparam int NG    = (N + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PW    = WW + $clog2(GROUP_SIZE) + 1;
  localparam int SUM_A = $clog2(N << WEIGHT_MAG_BITS) + 2;
  localparam int SUM_W = (SUM_A > OUT_SUM_W) ? SUM_A : OUT_SUM_W;

  logic signed [PW-1:0]    part_d [NG];
  logic signed [PW-1:0]    part_q [NG];
  logic signed [SUM_W-1:0] sum_d, sum_q;

  always_comb begin
    int j;
    logic signed [PW-1:0] w;
    logic signed [PW-1:0] acc;
    for (int g = 0; g < NG; g++) begin
      acc = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        j = g * GROUP_SIZE + k;
        if (j < N) begin
          w = PW'($signed(row_i[j*WW +: WW]));
          if (j == HISTORY_LEN || hist_i[j % HISTORY_LEN]) begin
            acc = acc + w;
          end else begin
            acc = acc - w;
          end
        end
      end
      part_d[g] = acc;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int g = 0; g < NG; g++) begin
      sum_d = sum_d + SUM_W'(part_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.part_en) begin
      part_q <= part_d;
    end
    if (ctrl_i.final_en) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== sv/pbp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbp_checker
// Port-level checks of the perceptron branch predictor, bound to the top.
// ----------------------------------------------------------------------------
module pbp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [pbp_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import pbp_pkg::*;

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // one request in flight
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("request accepted while another is in flight");

  // a fresh result is preceded by its accepted request
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(in_acc, 4))
    else $error("result without matching request");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind perceptron_branch_predictor_top pbp_checker u_pbp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
